// ===== rtl/mpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared types, codes and defaults for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int CURSOR_SIZE_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int COORD_WIDTH_DEF = 13;

  localparam int SCREEN_W  = 13;
  localparam int SUM_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  // command codes
  localparam logic [1:0] FUNC_DATA       = 2'd0;
  localparam logic [1:0] FUNC_CLEAR_SUMS = 2'd1;
  localparam logic [1:0] FUNC_CLEAR_ALL  = 2'd2;

  localparam int SYNC_BIT = 3;

  // event counter slots
  localparam int CNT_LEFT    = 0;
  localparam int CNT_RIGHT   = 1;
  localparam int CNT_MIDDLE  = 2;
  localparam int CNT_PACKETS = 3;
  localparam int NUM_CNT     = 4;

  typedef enum logic [1:0] {
    POS_FIRST,
    POS_SECOND,
    POS_THIRD
  } pos_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       from_aux;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [SCREEN_W-1:0]  data;
  } cfg_wr_t;

  // saturating add of a signed byte to a 32-bit signed total
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [7:0] d);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W-7){d[7]}}, d};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

// ===== rtl/mpd_in_reg.sv =====
// ----------------------------------------------------------------------------
// mpd_in_reg
// Input register: captures one item and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module mpd_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mpd_pkg::item_t in_item,
  input  logic           fire,
  output mpd_pkg::stage_t stage
);
  import mpd_pkg::*;

  logic accept;

  assign in_stall = stage.valid && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (accept) begin
      stage.valid <= 1'b1;
    end else if (fire) begin
      stage.valid <= 1'b0;
    end
    if (accept) begin
      stage.item <= in_item;
    end
  end

endmodule

// ===== rtl/mpd_cfg.sv =====
// ----------------------------------------------------------------------------
// mpd_cfg
// Screen size registers and the registered cursor position bounds.
// ----------------------------------------------------------------------------
module mpd_cfg #(
  parameter int CURSOR_SIZE = mpd_pkg::CURSOR_SIZE_DEF,
  parameter int COORD_WIDTH = mpd_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mpd_pkg::cfg_wr_t       wr,
  output logic [COORD_WIDTH-1:0] bound_x,
  output logic [COORD_WIDTH-1:0] bound_y
);
  import mpd_pkg::*;

  localparam int CMP_W = (COORD_WIDTH > SCREEN_W) ? COORD_WIDTH : SCREEN_W;
  localparam logic [SCREEN_W-1:0] CURSOR = SCREEN_W'(CURSOR_SIZE);
  localparam logic [CMP_W-1:0] COORD_MAX = CMP_W'({COORD_WIDTH{1'b1}});

  logic [SCREEN_W-1:0] screen_width;
  logic [SCREEN_W-1:0] screen_height;

  function automatic logic [COORD_WIDTH-1:0] bound_of(input logic [SCREEN_W-1:0] size);
    logic [CMP_W-1:0] m;
    m = (size > CURSOR) ? CMP_W'(size - CURSOR) : '0;
    if (m > COORD_MAX) begin
      m = COORD_MAX;
    end
    return m[COORD_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (wr.valid) begin
      case (wr.index)
        CFG_SCREEN_WIDTH:  screen_width  <= wr.data;
        CFG_SCREEN_HEIGHT: screen_height <= wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    bound_x <= bound_of(screen_width);
    bound_y <= bound_of(screen_height);
  end

endmodule

// ===== rtl/mpd_engine.sv =====
// ----------------------------------------------------------------------------
// mpd_engine
// Packet assembly, cursor tracking, totals and counters; result register.
// ----------------------------------------------------------------------------
module mpd_engine #(
  parameter int COUNT_WIDTH = mpd_pkg::COUNT_WIDTH_DEF,
  parameter int COORD_WIDTH = mpd_pkg::COORD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mpd_pkg::stage_t         stage,
  output logic                    fire,
  input  logic [COORD_WIDTH-1:0]  bound_x,
  input  logic [COORD_WIDTH-1:0]  bound_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    packet_done,
  output logic [COORD_WIDTH-1:0]  pos_x,
  output logic [COORD_WIDTH-1:0]  pos_y,
  output logic [2:0]              button_bits,
  output logic                    x_over,
  output logic                    y_over,
  output logic signed [31:0]      motion_x_sum,
  output logic signed [31:0]      motion_y_sum,
  output logic [COUNT_WIDTH-1:0]  left_count,
  output logic [COUNT_WIDTH-1:0]  right_count,
  output logic [COUNT_WIDTH-1:0]  middle_count,
  output logic [COUNT_WIDTH-1:0]  packets_seen
);
  import mpd_pkg::*;

  localparam int EXT_W = COORD_WIDTH + 2;

  pos_t pos, pos_next;
  logic is_byte, load_first, load_second, pkt;
  logic [7:0] first_byte, second_byte;
  logic [2:0] prior_buttons, buttons, fresh;
  logic [NUM_CNT-1:0] bump;
  logic [EXT_W-1:0] dx_ext, dy_ext, x_raw, y_raw;
  logic [COORD_WIDTH-1:0] x_next, y_next;
  logic [SUM_W-1:0] sum_x, sum_y, sum_x_next, sum_y_next;
  logic [COUNT_WIDTH-1:0] count [NUM_CNT];
  logic [COUNT_WIDTH-1:0] count_next [NUM_CNT];

  assign fire = stage.valid && (!out_valid || !out_stall);
  assign is_byte = (stage.item.func == FUNC_DATA) && stage.item.from_aux;

  // byte position within the packet
  always_comb begin
    pos_next    = pos;
    load_first  = 1'b0;
    load_second = 1'b0;
    pkt         = 1'b0;
    unique case (pos)
      POS_FIRST: begin
        if (is_byte && stage.item.data_byte[SYNC_BIT]) begin
          load_first = 1'b1;
          pos_next   = POS_SECOND;
        end
      end
      POS_SECOND: begin
        if (is_byte) begin
          load_second = 1'b1;
          pos_next    = POS_THIRD;
        end
      end
      POS_THIRD: begin
        if (is_byte) begin
          pkt      = 1'b1;
          pos_next = POS_FIRST;
        end
      end
      default: pos_next = POS_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_FIRST;
    end else if (fire) begin
      pos <= pos_next;
    end
  end

  assign buttons = first_byte[2:0];
  assign fresh   = buttons & ~prior_buttons;
  assign bump    = {1'b1, fresh};

  // cursor motion: x follows dx, y grows downward so it takes -dy
  assign dx_ext = {{(EXT_W-8){second_byte[7]}}, second_byte};
  assign dy_ext = {{(EXT_W-8){stage.item.data_byte[7]}}, stage.item.data_byte};
  assign x_raw  = {2'b00, pos_x} + dx_ext;
  assign y_raw  = {2'b00, pos_y} - dy_ext;

  always_comb begin
    x_next = '0;
    y_next = '0;
    if (!x_raw[EXT_W-1]) begin
      x_next = (x_raw[EXT_W-2:0] > {1'b0, bound_x}) ? bound_x : x_raw[COORD_WIDTH-1:0];
    end
    if (!y_raw[EXT_W-1]) begin
      y_next = (y_raw[EXT_W-2:0] > {1'b0, bound_y}) ? bound_y : y_raw[COORD_WIDTH-1:0];
    end
  end

  // totals
  always_comb begin
    sum_x_next = sum_x;
    sum_y_next = sum_y;
    if (pkt) begin
      sum_x_next = sat_add(sum_x, second_byte);
      sum_y_next = sat_add(sum_y, stage.item.data_byte);
    end
    if (stage.item.func == FUNC_CLEAR_SUMS || stage.item.func == FUNC_CLEAR_ALL) begin
      sum_x_next = '0;
      sum_y_next = '0;
    end
  end

  // counters, saturating
  always_comb begin
    for (int k = 0; k < NUM_CNT; k++) begin
      count_next[k] = count[k];
      if (pkt && bump[k] && !(&count[k])) begin
        count_next[k] = count[k] + 1'b1;
      end
      if (stage.item.func == FUNC_CLEAR_ALL) begin
        count_next[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_byte    <= '0;
      second_byte   <= '0;
      prior_buttons <= '0;
      pos_x         <= '0;
      pos_y         <= '0;
      button_bits   <= '0;
      x_over        <= 1'b0;
      y_over        <= 1'b0;
      sum_x         <= '0;
      sum_y         <= '0;
      for (int k = 0; k < NUM_CNT; k++) begin
        count[k] <= '0;
      end
    end else if (fire) begin
      if (load_first) begin
        first_byte <= stage.item.data_byte;
      end
      if (load_second) begin
        second_byte <= stage.item.data_byte;
      end
      if (pkt) begin
        prior_buttons <= buttons;
        button_bits   <= buttons;
        x_over        <= first_byte[6];
        y_over        <= first_byte[7];
        pos_x         <= x_next;
        pos_y         <= y_next;
      end
      sum_x <= sum_x_next;
      sum_y <= sum_y_next;
      for (int k = 0; k < NUM_CNT; k++) begin
        count[k] <= count_next[k];
      end
    end
  end

  // result handshake; state only moves when a new result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      packet_done <= pkt;
    end
  end

  assign motion_x_sum = sum_x;
  assign motion_y_sum = sum_y;
  assign left_count   = count[CNT_LEFT];
  assign right_count  = count[CNT_RIGHT];
  assign middle_count = count[CNT_MIDDLE];
  assign packets_seen = count[CNT_PACKETS];

endmodule

// ===== rtl/mouse_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// mouse_packet_decoder
// PS/2 mouse three-byte packet decoder with cursor tracking and statistics.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | func, data_byte, from_aux
//  out     | out_valid / out_stall| packet_done, pos_x/y, buttons, flags, totals
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (screen width, height)
//
//  One item per cycle sustained while the output is not stalled; a result is
//  valid once its item has passed the input register, then the result register.
//  Synchronous reset clears the packet assembly, position, totals, counters
//  and restores the 640x480 screen size. A stalled result holds; the input
//  register keeps taking items until it is also full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module mouse_packet_decoder #(
  parameter int CURSOR_SIZE = mpd_pkg::CURSOR_SIZE_DEF,
  parameter int COUNT_WIDTH = mpd_pkg::COUNT_WIDTH_DEF,
  parameter int COORD_WIDTH = mpd_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      func,
  input  logic [7:0]                      data_byte,
  input  logic                            from_aux,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            packet_done,
  output logic [COORD_WIDTH-1:0]          pos_x,
  output logic [COORD_WIDTH-1:0]          pos_y,
  output logic [2:0]                      button_bits,
  output logic                            x_over,
  output logic                            y_over,
  output logic signed [31:0]              motion_x_sum,
  output logic signed [31:0]              motion_y_sum,
  output logic [COUNT_WIDTH-1:0]          left_count,
  output logic [COUNT_WIDTH-1:0]          right_count,
  output logic [COUNT_WIDTH-1:0]          middle_count,
  output logic [COUNT_WIDTH-1:0]          packets_seen,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpd_pkg::SCREEN_W-1:0]    cfg_data
);
  import mpd_pkg::*;

  item_t                  in_item;
  stage_t                 stage;
  cfg_wr_t                cfg_wr;
  logic                   fire;
  logic [COORD_WIDTH-1:0] bound_x;
  logic [COORD_WIDTH-1:0] bound_y;

  assign in_item   = '{func: func, data_byte: data_byte, from_aux: from_aux};
  assign cfg_ready = 1'b1;
  assign cfg_wr    = '{valid: cfg_valid && cfg_ready, index: cfg_index, data: cfg_data};

  mpd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .fire     (fire),
    .stage    (stage)
  );

  mpd_cfg #(
    .CURSOR_SIZE (CURSOR_SIZE),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr      (cfg_wr),
    .bound_x (bound_x),
    .bound_y (bound_y)
  );

  mpd_engine #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .fire         (fire),
    .bound_x      (bound_x),
    .bound_y      (bound_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .packet_done  (packet_done),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .button_bits  (button_bits),
    .x_over       (x_over),
    .y_over       (y_over),
    .motion_x_sum (motion_x_sum),
    .motion_y_sum (motion_y_sum),
    .left_count   (left_count),
    .right_count  (right_count),
    .middle_count (middle_count),
    .packets_seen (packets_seen)
  );

endmodule

// ===== rtl/mpd_checker.sv =====
// ----------------------------------------------------------------------------
// mpd_checker
// Port-level checks for the mouse packet decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mpd_checker #(
  parameter int COUNT_WIDTH = mpd_pkg::COUNT_WIDTH_DEF,
  parameter int COORD_WIDTH = mpd_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   packet_done,
  input logic [COORD_WIDTH-1:0] pos_x,
  input logic [COORD_WIDTH-1:0] pos_y,
  input logic [COUNT_WIDTH-1:0] packets_seen
);
  import mpd_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a finished packet is always counted
  a_packet_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_done |-> packets_seen != '0)
    else $error("packet reported but packet count is zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(pos_y)
      && $stable(packets_seen))
    else $error("stalled result changed");

endmodule

bind mouse_packet_decoder mpd_checker #(
  .COUNT_WIDTH (COUNT_WIDTH),
  .COORD_WIDTH (COORD_WIDTH)
) u_mpd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .packet_done  (packet_done),
  .pos_x        (pos_x),
  .pos_y        (pos_y),
  .packets_seen (packets_seen)
);

// ===== dv/mouse_packet_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mouse_packet_decoder_tb
// Self-checking bench for the PS/2 mouse packet decoder. Bytes, commands and
// noise are driven with random gaps and output stalls. A scoreboard tracks
// packet assembly, cursor clamping, button edges and saturating totals, and
// compares every result item field by field. Screen size is changed between
// phases while the block is drained.
// ----------------------------------------------------------------------------
module mouse_packet_decoder_tb;
  import mpd_pkg::*;

  localparam int          XY_W        = COORD_WIDTH_DEF;
  localparam int          CNT_W       = COUNT_WIDTH_DEF;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_WAIT  = 8;
  localparam int          PRINT_CAP   = 50;

  typedef struct {
    logic             done;
    logic [XY_W-1:0]  x;
    logic [XY_W-1:0]  y;
    logic [2:0]       btn;
    logic             xo;
    logic             yo;
    logic [31:0]      sum_x;
    logic [31:0]      sum_y;
    logic [CNT_W-1:0] left;
    logic [CNT_W-1:0] right;
    logic [CNT_W-1:0] middle;
    logic [CNT_W-1:0] packets;
  } mouse_report_t;

  class packet_scoreboard;
    int unsigned     errors;
    mouse_report_t   expected_reports[$];

    logic [SCREEN_W-1:0] width;
    logic [SCREEN_W-1:0] height;
    pos_t            asm_pos;
    logic [7:0]      first_b;
    logic [7:0]      second_b;
    logic [2:0]      prior_btn;
    logic [2:0]      btn_q;
    logic            xo_q;
    logic            yo_q;
    int              cur_x;
    int              cur_y;
    longint          sum_x;
    longint          sum_y;
    longint unsigned counts[NUM_CNT];

    function new();
      errors    = 0;
      width     = SCREEN_WIDTH_RST;
      height    = SCREEN_HEIGHT_RST;
      asm_pos   = POS_FIRST;
      first_b   = '0;
      second_b  = '0;
      prior_btn = '0;
      btn_q     = '0;
      xo_q      = 1'b0;
      yo_q      = 1'b0;
      cur_x     = 0;
      cur_y     = 0;
      sum_x     = 0;
      sum_y     = 0;
      foreach (counts[i]) counts[i] = 0;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SCREEN_W-1:0] val);
      if (idx == CFG_SCREEN_WIDTH) width = val;
      else height = val;
    endfunction

    function void bump(int k);
      if (counts[k] < {CNT_W{1'b1}}) counts[k]++;
    endfunction

    function longint sat_total(longint a, int d);
      longint s;
      s = a + d;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s;
    endfunction

    // cursor limit: screen less cursor, never below zero
    function int pos_bound(logic [SCREEN_W-1:0] size);
      int m;
      m = (int'(size) > CURSOR_SIZE_DEF) ? int'(size) - CURSOR_SIZE_DEF : 0;
      if (m > (1 << XY_W) - 1) m = (1 << XY_W) - 1;
      return m;
    endfunction

    function int clamp(int v, int hi);
      if (v < 0) v = 0;
      if (v > hi) v = hi;
      return v;
    endfunction

    function void close_packet(logic [7:0] third);
      int       dx;
      int       dy;
      logic [2:0] btn;
      logic [2:0] fresh;
      dx    = $signed(second_b);
      dy    = $signed(third);
      btn   = first_b[2:0];
      fresh = btn & ~prior_btn;
      prior_btn = btn;
      if (fresh[0]) bump(CNT_LEFT);
      if (fresh[1]) bump(CNT_RIGHT);
      if (fresh[2]) bump(CNT_MIDDLE);
      btn_q = btn;
      xo_q  = first_b[6];
      yo_q  = first_b[7];
      cur_x = clamp(cur_x + dx, pos_bound(width));
      cur_y = clamp(cur_y - dy, pos_bound(height));
      sum_x = sat_total(sum_x, dx);
      sum_y = sat_total(sum_y, dy);
      bump(CNT_PACKETS);
    endfunction

    function mouse_report_t decode_item(logic [1:0] f, logic [7:0] d, logic aux);
      mouse_report_t r;
      r.done = 1'b0;
      if (f == FUNC_DATA) begin
        if (aux) begin
          case (asm_pos)
            POS_FIRST: begin
              // resync: a first byte without the always-one bit is dropped
              if (d[SYNC_BIT]) begin
                first_b = d;
                asm_pos = POS_SECOND;
              end
            end
            POS_SECOND: begin
              second_b = d;
              asm_pos  = POS_THIRD;
            end
            default: begin
              close_packet(d);
              asm_pos = POS_FIRST;
              r.done  = 1'b1;
            end
          endcase
        end
      end else if (f == FUNC_CLEAR_SUMS) begin
        sum_x = 0;
        sum_y = 0;
      end else if (f == FUNC_CLEAR_ALL) begin
        sum_x = 0;
        sum_y = 0;
        foreach (counts[i]) counts[i] = 0;
      end
      r.x       = cur_x[XY_W-1:0];
      r.y       = cur_y[XY_W-1:0];
      r.btn     = btn_q;
      r.xo      = xo_q;
      r.yo      = yo_q;
      r.sum_x   = sum_x[31:0];
      r.sum_y   = sum_y[31:0];
      r.left    = counts[CNT_LEFT][CNT_W-1:0];
      r.right   = counts[CNT_RIGHT][CNT_W-1:0];
      r.middle  = counts[CNT_MIDDLE][CNT_W-1:0];
      r.packets = counts[CNT_PACKETS][CNT_W-1:0];
      return r;
    endfunction

    function void note_item(logic [1:0] f, logic [7:0] d, logic aux);
      expected_reports.push_back(decode_item(f, d, aux));
    endfunction

    task report_mismatch(string what);
      if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_report(mouse_report_t got);
      mouse_report_t want;
      if (expected_reports.size() == 0) begin
        report_mismatch("result item with nothing expected");
        return;
      end
      want = expected_reports.pop_front();
      cmp_field("packet_done", got.done, want.done);
      cmp_field("pos_x", got.x, want.x);
      cmp_field("pos_y", got.y, want.y);
      cmp_field("button_bits", got.btn, want.btn);
      cmp_field("x_over", got.xo, want.xo);
      cmp_field("y_over", got.yo, want.yo);
      cmp_field("motion_x_sum", got.sum_x, want.sum_x);
      cmp_field("motion_y_sum", got.sum_y, want.sum_y);
      cmp_field("left_count", got.left, want.left);
      cmp_field("right_count", got.right, want.right);
      cmp_field("middle_count", got.middle, want.middle);
      cmp_field("packets_seen", got.packets, want.packets);
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            func;
  logic [7:0]            data_byte;
  logic                  from_aux;
  logic                  out_valid;
  logic                  out_stall;
  logic                  packet_done;
  logic [XY_W-1:0]       pos_x;
  logic [XY_W-1:0]       pos_y;
  logic [2:0]            button_bits;
  logic                  x_over;
  logic                  y_over;
  logic signed [31:0]    motion_x_sum;
  logic signed [31:0]    motion_y_sum;
  logic [CNT_W-1:0]      left_count;
  logic [CNT_W-1:0]      right_count;
  logic [CNT_W-1:0]      middle_count;
  logic [CNT_W-1:0]      packets_seen;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [SCREEN_W-1:0]   cfg_data;

  packet_scoreboard sb;
  int unsigned      cycle_count;
  logic             steady;

  mouse_packet_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .data_byte    (data_byte),
    .from_aux     (from_aux),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .packet_done  (packet_done),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .button_bits  (button_bits),
    .x_over       (x_over),
    .y_over       (y_over),
    .motion_x_sum (motion_x_sum),
    .motion_y_sum (motion_y_sum),
    .left_count   (left_count),
    .right_count  (right_count),
    .middle_count (middle_count),
    .packets_seen (packets_seen),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL mouse_packet_decoder");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result monitor
  always @(posedge clk) begin
    mouse_report_t got;
    if (!rst && out_valid && !out_stall) begin
      got.done    = packet_done;
      got.x       = pos_x;
      got.y       = pos_y;
      got.btn     = button_bits;
      got.xo      = x_over;
      got.yo      = y_over;
      got.sum_x   = motion_x_sum;
      got.sum_y   = motion_y_sum;
      got.left    = left_count;
      got.right   = right_count;
      got.middle  = middle_count;
      got.packets = packets_seen;
      sb.check_report(got);
    end
  end

  // receiver back-pressure, with occasional long stall-free stretches
  initial begin
    int run;
    int hold;
    out_stall = 1'b0;
    forever begin
      run  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : rand_len() + 1;
      hold = rand_len();
      repeat (run) begin
        @(negedge clk);
        out_stall = 1'b0;
      end
      repeat (hold) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
    end
  end

  task automatic send_item(logic [1:0] f, logic [7:0] d, logic aux);
    int g;
    @(negedge clk);
    func      = f;
    data_byte = d;
    from_aux  = aux;
    in_valid  = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_item(f, d, aux);
    g = steady ? 0 : rand_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_byte(logic [7:0] d);
    send_item(FUNC_DATA, d, 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCREEN_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_screen(logic [SCREEN_W-1:0] w, logic [SCREEN_W-1:0] h);
    wait_drained();
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
  endtask

  // one noise item: commands, foreign bytes, unused code or a stray byte
  task automatic send_noise(ref int counted);
    int         r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    b = 8'($urandom_range(0, 255));
    if (r < 35) begin
      send_item(FUNC_DATA, b, 1'b0);
    end else if (r < 50) begin
      send_item(FUNC_UNUSED, b, 1'($urandom_range(0, 1)));
    end else if (r < 65) begin
      send_item(FUNC_CLEAR_SUMS, b, 1'($urandom_range(0, 1)));
      counted++;
    end else if (r < 75) begin
      send_item(FUNC_CLEAR_ALL, b, 1'($urandom_range(0, 1)));
      counted++;
    end else begin
      b[SYNC_BIT] = 1'b0;
      send_byte(b);
    end
  endtask

  task automatic send_random(int n);
    int         counted;
    logic [7:0] b;
    counted = 0;
    while (counted < n) begin
      if ($urandom_range(0, 99) < 80) begin
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) != 0) b[SYNC_BIT] = 1'b1;
        send_byte(b);
        if ($urandom_range(0, 9) == 0) send_noise(counted);
        send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) send_noise(counted);
        send_byte(8'($urandom_range(0, 255)));
        counted += 3;
      end else begin
        send_noise(counted);
      end
    end
  endtask

  initial begin
    sb          = new();
    cycle_count = 0;
    steady      = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    func        = FUNC_DATA;
    data_byte   = '0;
    from_aux    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_SCREEN_WIDTH;
    cfg_data    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: resync drop, foreign byte, unused code, motion extremes
    send_byte(8'h00);
    send_item(FUNC_DATA, 8'hFF, 1'b0);
    send_item(FUNC_UNUSED, 8'hA5, 1'b1);
    send_byte(8'hCF);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'h08);
    send_byte(8'h80);
    send_byte(8'h7F);
    // commands in mid-packet keep the assembly
    send_byte(8'h09);
    send_item(FUNC_CLEAR_ALL, 8'h00, 1'b1);
    send_byte(8'h01);
    send_item(FUNC_CLEAR_SUMS, 8'h00, 1'b0);
    send_byte(8'hFF);
    send_byte(8'h0A);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h0C);
    send_item(FUNC_DATA, 8'h55, 1'b0);
    send_byte(8'h00);
    send_byte(8'h00);
    // screen no larger than the cursor pins the position at zero
    set_screen(13'd0, 13'd0);
    send_byte(8'h08);
    send_byte(8'h7F);
    send_byte(8'h80);

    set_screen(13'h1FFF, 13'h1FFF);
    send_random(60);
    set_screen(13'd24, 13'd17);
    steady = 1'b1;
    send_random(60);
    steady = 1'b0;
    set_screen(13'd8, 13'd9);
    send_random(50);
    set_screen(SCREEN_W'($urandom_range(0, 8191)), SCREEN_W'($urandom_range(0, 8191)));
    send_random(60);
    set_screen(13'd0, 13'h1FFF);
    send_random(50);
    set_screen(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST);
    send_random(60);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS mouse_packet_decoder");
    end else begin
      $display("FAIL mouse_packet_decoder");
    end
    $finish;
  end

endmodule

// ===== mouse_packet_decoder.f =====
rtl/mpd_pkg.sv
rtl/mpd_in_reg.sv
rtl/mpd_cfg.sv
rtl/mpd_engine.sv
rtl/mouse_packet_decoder.sv
rtl/mpd_checker.sv
dv/mouse_packet_decoder_tb.sv
